// ----- rtl/core/can_frame_deframer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// can_frame_deframer_unit_assert.svh
// Assertion macros used by the deframer parser module (clock aclk, reset aresetn).
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define CAN_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define CFD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer assertion failed: same-cycle implication");

// next-cycle implication
`define CFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer assertion failed: next-cycle implication");

`endif

// ----- rtl/core/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants of the XOR-checksum frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam logic [7:0] START_BYTE = 8'hA5;
    localparam logic [7:0] TYPE_BYTE  = 8'h01;
    localparam int         OUT_BYTES  = 8;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } cfd_item_t;

endpackage

// ----- rtl/core/cfd_in_stage.sv -----
// ----------------------------------------------------------------------------
// cfd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module cfd_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  logic                take,
    output cfd_pkg::cfd_item_t  item
);
    import cfd_pkg::*;

    logic       vld_reg, vld_next;
    logic [7:0] data_reg, data_next;
    logic       accept;

    assign s_ready = !vld_reg || take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        vld_next  = accept || (vld_reg && !take);
        data_next = accept ? s_rx_byte : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        data_reg <= data_next;
    end

    assign item.vld  = vld_reg;
    assign item.data = data_reg;

endmodule

// ----- rtl/core/cfd_parser.sv -----
// ----------------------------------------------------------------------------
// cfd_parser
// Frame state machine, running XOR, payload store and result register.
// ----------------------------------------------------------------------------
`include "can_frame_deframer_unit_assert.svh"

module cfd_parser #(
    parameter int MAX_PAYLOAD = 64,
    parameter int KEPT_BYTES  = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfd_pkg::cfd_item_t  item,
    output logic                take,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_msg_id,
    output logic [3:0]          m_msg_len,
    output logic [7:0]          m_byte [cfd_pkg::OUT_BYTES]
);
    import cfd_pkg::*;

    localparam int         PW      = $clog2(KEPT_BYTES + 1);
    localparam logic [7:0] MaxLen  = 8'(MAX_PAYLOAD);
    localparam logic [7:0] KeptLen = 8'(KEPT_BYTES);
    localparam logic [PW-1:0] KeptPos = PW'(KEPT_BYTES);

    typedef enum logic [3:0] {
        PH_HUNT, PH_TYPE, PH_FLAGS, PH_ID0, PH_ID1, PH_ID2, PH_ID3,
        PH_LEN, PH_DATA, PH_CHECK
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      xor_reg, xor_next;
    logic [7:0]      left_reg, left_next;
    logic [3:0]      keep_reg, keep_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [15:0]     id_reg, id_next;
    logic [7:0]      store_reg [KEPT_BYTES];
    logic            store_we;
    logic            hit;
    logic            m_valid_reg, m_valid_next;
    logic [15:0]     m_id_reg;
    logic [3:0]      m_len_reg;
    logic [7:0]      m_byte_reg [OUT_BYTES];
    logic [7:0]      res_byte [OUT_BYTES];
    logic [7:0]      b;

    assign b    = item.data;
    // only a checksum byte can load the result register
    assign take = item.vld && (phase_reg != PH_CHECK || !m_valid_reg || m_ready);

    always_comb begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        left_next  = left_reg;
        keep_next  = keep_reg;
        pos_next   = pos_reg;
        id_next    = id_reg;
        store_we   = 1'b0;
        hit        = 1'b0;
        if (take) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (b == START_BYTE) begin
                        xor_next   = b;
                        id_next    = '0;
                        pos_next   = '0;
                        left_next  = '0;
                        keep_next  = '0;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (b != TYPE_BYTE) begin
                        phase_next = PH_HUNT;
                    end else begin
                        xor_next   = xor_reg ^ b;
                        phase_next = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    xor_next   = xor_reg ^ b;
                    phase_next = PH_ID0;
                end
                PH_ID0: begin
                    xor_next   = xor_reg ^ b;
                    id_next    = {8'h00, b};
                    phase_next = PH_ID1;
                end
                PH_ID1: begin
                    xor_next   = xor_reg ^ b;
                    id_next    = {b, id_reg[7:0]};
                    phase_next = PH_ID2;
                end
                PH_ID2: begin
                    xor_next   = xor_reg ^ b;
                    phase_next = PH_ID3;
                end
                PH_ID3: begin
                    xor_next   = xor_reg ^ b;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (b > MaxLen) begin
                        phase_next = PH_HUNT;
                    end else begin
                        xor_next   = xor_reg ^ b;
                        left_next  = b;
                        pos_next   = '0;
                        keep_next  = (b > KeptLen) ? KeptLen[3:0] : b[3:0];
                        phase_next = (b == 8'h00) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA: begin
                    xor_next  = xor_reg ^ b;
                    store_we  = (pos_reg != KeptPos);
                    pos_next  = (pos_reg != KeptPos) ? pos_reg + 1'b1 : pos_reg;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_HUNT;
                    hit        = (b == xor_reg);
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < OUT_BYTES; k++) begin
            res_byte[k] = '0;
            if (k < KEPT_BYTES && 4'(k) < keep_reg) begin
                res_byte[k] = store_reg[k];
            end
        end
        m_valid_next = hit || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            xor_reg     <= '0;
            left_reg    <= '0;
            keep_reg    <= '0;
            pos_reg     <= '0;
            id_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            xor_reg     <= xor_next;
            left_reg    <= left_next;
            keep_reg    <= keep_next;
            pos_reg     <= pos_next;
            id_reg      <= id_next;
            m_valid_reg <= m_valid_next;
            for (int k = 0; k < KEPT_BYTES; k++) begin
                if (store_we && pos_reg == PW'(k)) begin
                    store_reg[k] <= b;
                end
            end
            if (hit) begin
                m_id_reg   <= id_reg;
                m_len_reg  <= keep_reg;
                m_byte_reg <= res_byte;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_msg_id  = m_id_reg;
    assign m_msg_len = m_len_reg;
    assign m_byte    = m_byte_reg;

    `CFD_ASSERT_NEXT(a_result_only_from_check, !hit && (!m_valid_reg || m_ready), !m_valid_reg)
    `CFD_ASSERT_IMPLY(a_len_clamped, m_valid_reg, m_len_reg <= KeptLen[3:0])
    `CFD_ASSERT_IMPLY(a_data_has_bytes, phase_reg == PH_DATA, left_reg != 8'd0)
    `CFD_ASSERT_IMPLY(a_pos_in_range, phase_reg == PH_DATA, pos_reg <= KeptPos)

endmodule

// ----- rtl/core/can_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// can_frame_deframer_unit
// XOR-checksum frame deframer, one received byte per item.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle except while a checksum byte is held up. Each
// byte sits in an input register, then passes the frame state machine; a frame
// with a good checksum puts one result in the output register as its checksum
// byte is taken from the input register. s_ready depends combinationally on
// m_ready: while a result waits in the output register, only the next checksum
// byte is held up. Frames: 0xA5, 0x01, flags, four identifier bytes (LSB first),
// length 0..MAX_PAYLOAD, payload, XOR checksum.
module can_frame_deframer_unit #(
    parameter int MAX_PAYLOAD = 64,
    parameter int KEPT_BYTES  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_msg_id,
    output logic [3:0]  m_msg_len,
    output logic [7:0]  m_byte_0,
    output logic [7:0]  m_byte_1,
    output logic [7:0]  m_byte_2,
    output logic [7:0]  m_byte_3,
    output logic [7:0]  m_byte_4,
    output logic [7:0]  m_byte_5,
    output logic [7:0]  m_byte_6,
    output logic [7:0]  m_byte_7
);
    import cfd_pkg::*;

    cfd_item_t  item;
    logic       take;
    logic [7:0] m_byte [OUT_BYTES];

    cfd_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .take      (take),
        .item      (item)
    );

    cfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .KEPT_BYTES  (KEPT_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .take      (take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_msg_id  (m_msg_id),
        .m_msg_len (m_msg_len),
        .m_byte    (m_byte)
    );

    assign m_byte_0 = m_byte[0];
    assign m_byte_1 = m_byte[1];
    assign m_byte_2 = m_byte[2];
    assign m_byte_3 = m_byte[3];
    assign m_byte_4 = m_byte[4];
    assign m_byte_5 = m_byte[5];
    assign m_byte_6 = m_byte[6];
    assign m_byte_7 = m_byte[7];

endmodule

// ----- sim/tb_can_frame_deframer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_frame_deframer_unit
// Self-checking bench for the XOR-checksum frame deframer.
// ----------------------------------------------------------------------------
// A short table of directed bytes covers hunting, a wrong type byte, a length
// above the limit, a bad checksum and a good empty frame. Random frames follow:
// mostly well formed with random content and lengths, some with broken type,
// length or checksum, and some noise in between. A byte-level model of the frame
// parser predicts every result; results are compared field by field in order.
// The sender idles in bursts, the receiver stalls on its own pattern.
module tb_can_frame_deframer_unit;

    import cfd_pkg::*;

    localparam int MAX_PAYLOAD    = 64;
    localparam int KEPT_BYTES     = 8;
    localparam int ITEMS          = 1500;
    localparam int LATENCY        = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [3:0] {
        SEEK_SOF, GET_TYPE, GET_FLAGS, GET_ID0, GET_ID1, GET_ID2, GET_ID3,
        GET_LEN, GET_DATA, GET_CHK
    } rx_state_t;

    typedef enum logic [1:0] {
        ROW_PRED, ROW_NONE, ROW_RES
    } row_kind_t;

    typedef struct packed {
        logic [15:0]     id;
        logic [3:0]      len;
        logic [7:0][7:0] data;
    } frame_result_t;

    typedef struct packed {
        logic [7:0]    rx;
        row_kind_t     kind;
        frame_result_t res;
    } dir_row_t;

    localparam frame_result_t NO_RES = '0;
    localparam int DIR_COUNT = 28;

    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        '{8'hA5, ROW_PRED, NO_RES},
        '{8'hA5, ROW_NONE, NO_RES},     // wrong type, must not restart
        '{8'hA5, ROW_PRED, NO_RES},
        '{8'h01, ROW_PRED, NO_RES},
        '{8'hFF, ROW_PRED, NO_RES},
        '{8'hFF, ROW_PRED, NO_RES},
        '{8'hFF, ROW_PRED, NO_RES},
        '{8'hFF, ROW_PRED, NO_RES},
        '{8'hFF, ROW_PRED, NO_RES},
        '{8'h41, ROW_NONE, NO_RES},     // length 65
        '{8'hA5, ROW_PRED, NO_RES},
        '{8'h01, ROW_PRED, NO_RES},
        '{8'h80, ROW_PRED, NO_RES},
        '{8'h00, ROW_PRED, NO_RES},
        '{8'h00, ROW_PRED, NO_RES},
        '{8'h00, ROW_PRED, NO_RES},
        '{8'h00, ROW_PRED, NO_RES},
        '{8'h00, ROW_PRED, NO_RES},
        '{8'hA5, ROW_NONE, NO_RES},     // bad checksum, not a start
        '{8'hA5, ROW_PRED, NO_RES},
        '{8'h01, ROW_PRED, NO_RES},
        '{8'h00, ROW_PRED, NO_RES},
        '{8'h34, ROW_PRED, NO_RES},
        '{8'h12, ROW_PRED, NO_RES},
        '{8'hFF, ROW_PRED, NO_RES},
        '{8'hFF, ROW_PRED, NO_RES},
        '{8'h00, ROW_PRED, NO_RES},
        '{8'h82, ROW_RES,  '{16'h1234, 4'd0, 64'h0}}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_msg_id;
    logic [3:0]  m_msg_len;
    logic [7:0]  m_byte_0, m_byte_1, m_byte_2, m_byte_3;
    logic [7:0]  m_byte_4, m_byte_5, m_byte_6, m_byte_7;

    rx_state_t   rx_state = SEEK_SOF;
    logic [7:0]  run_xor = '0;
    logic [6:0]  left_cnt = '0;
    logic [6:0]  frame_len = '0;
    logic [6:0]  pay_pos = '0;
    logic [15:0] id_low = '0;
    logic [7:0]  kept_bytes [KEPT_BYTES] = '{default: '0};

    frame_result_t expected_frames [$];
    int unsigned   errors = 0;
    int unsigned   item_count = 0;
    int            burst_left = 1;
    int unsigned   idle_cycles = 0;
    int unsigned   rdy_left = 0;
    int unsigned   rdy_mode = 0;

    can_frame_deframer_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .KEPT_BYTES (KEPT_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_msg_id (m_msg_id),
        .m_msg_len(m_msg_len),
        .m_byte_0 (m_byte_0),
        .m_byte_1 (m_byte_1),
        .m_byte_2 (m_byte_2),
        .m_byte_3 (m_byte_3),
        .m_byte_4 (m_byte_4),
        .m_byte_5 (m_byte_5),
        .m_byte_6 (m_byte_6),
        .m_byte_7 (m_byte_7)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        errors++;
    endtask

    function automatic void deframe_byte(input logic [7:0] b, output logic hit,
                                         output frame_result_t res);
        int keep;
        hit = 1'b0;
        res = NO_RES;
        case (rx_state)
            SEEK_SOF: begin
                if (b == START_BYTE) begin
                    run_xor   = b;
                    id_low    = '0;
                    pay_pos   = '0;
                    left_cnt  = '0;
                    frame_len = '0;
                    rx_state  = GET_TYPE;
                end
            end
            GET_TYPE: begin
                if (b != TYPE_BYTE) begin
                    rx_state = SEEK_SOF;
                end else begin
                    run_xor ^= b;
                    rx_state = GET_FLAGS;
                end
            end
            GET_FLAGS: begin
                run_xor ^= b;
                rx_state = GET_ID0;
            end
            GET_ID0: begin
                run_xor ^= b;
                id_low   = {8'h00, b};
                rx_state = GET_ID1;
            end
            GET_ID1: begin
                run_xor ^= b;
                id_low[15:8] = b;
                rx_state = GET_ID2;
            end
            GET_ID2: begin
                run_xor ^= b;
                rx_state = GET_ID3;
            end
            GET_ID3: begin
                run_xor ^= b;
                rx_state = GET_LEN;
            end
            GET_LEN: begin
                if (int'(b) > MAX_PAYLOAD) begin
                    rx_state = SEEK_SOF;
                end else begin
                    run_xor ^= b;
                    frame_len = b[6:0];
                    left_cnt  = b[6:0];
                    pay_pos   = '0;
                    rx_state  = (b == 8'h00) ? GET_CHK : GET_DATA;
                end
            end
            GET_DATA: begin
                run_xor ^= b;
                if (int'(pay_pos) < KEPT_BYTES) kept_bytes[pay_pos[2:0]] = b;
                pay_pos  = pay_pos + 7'd1;
                left_cnt = left_cnt - 7'd1;
                if (left_cnt == '0) rx_state = GET_CHK;
            end
            GET_CHK: begin
                rx_state = SEEK_SOF;
                if (b == run_xor) begin
                    hit  = 1'b1;
                    keep = (int'(frame_len) > KEPT_BYTES) ? KEPT_BYTES : int'(frame_len);
                    if (keep > OUT_BYTES) keep = OUT_BYTES;
                    res.id  = id_low;
                    res.len = 4'(keep);
                    for (int k = 0; k < OUT_BYTES; k++)
                        res.data[k] = (k < keep) ? kept_bytes[k] : 8'h00;
                end
            end
            default: rx_state = SEEK_SOF;
        endcase
    endfunction

    task automatic push_rx(input logic [7:0] b, input row_kind_t kind,
                           input frame_result_t typed);
        logic          hit;
        frame_result_t res;
        int            gap;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        deframe_byte(b, hit, res);
        if (kind == ROW_RES) expected_frames.push_back(typed);
        else if (kind == ROW_PRED && hit) expected_frames.push_back(res);
        item_count++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0) gap = 0;
            else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 24);
            else gap = $urandom_range(1, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_frames.size() != 0);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic send_random_frame();
        int         len;
        int         flaw;
        int         pick;
        logic [7:0] chk;
        logic [7:0] b;
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) push_rx(8'($urandom_range(0, 255)), ROW_PRED, NO_RES);
        pick = $urandom_range(0, 99);
        if (pick < 65) len = $urandom_range(0, 8);
        else if (pick < 88) len = $urandom_range(9, 20);
        else if (pick < 97) len = $urandom_range(21, MAX_PAYLOAD - 1);
        else len = MAX_PAYLOAD;
        flaw = $urandom_range(0, 19);
        chk  = START_BYTE;
        push_rx(START_BYTE, ROW_PRED, NO_RES);
        if (flaw == 0) begin
            b = ($urandom_range(0, 1) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
            if (b == TYPE_BYTE) b = ~b;
            push_rx(b, ROW_PRED, NO_RES);
            return;
        end
        chk ^= TYPE_BYTE;
        push_rx(TYPE_BYTE, ROW_PRED, NO_RES);
        repeat (5) begin
            b = 8'($urandom_range(0, 255));
            chk ^= b;
            push_rx(b, ROW_PRED, NO_RES);
        end
        if (flaw == 1) begin
            push_rx(8'($urandom_range(MAX_PAYLOAD + 1, 255)), ROW_PRED, NO_RES);
            return;
        end
        chk ^= 8'(len);
        push_rx(8'(len), ROW_PRED, NO_RES);
        repeat (len) begin
            b = 8'($urandom_range(0, 255));
            chk ^= b;
            push_rx(b, ROW_PRED, NO_RES);
        end
        if (flaw == 2 || flaw == 3) chk ^= 8'($urandom_range(1, 255));
        push_rx(chk, ROW_PRED, NO_RES);
    endtask

    // receiver stall pattern: always ready, coin flip, or ready with one chance in four
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(0, 2);
            rdy_left <= $urandom_range(10, 60);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        frame_result_t want;
        logic [7:0]    got_byte [OUT_BYTES];
        if (aresetn && m_valid && m_ready) begin
            got_byte = '{m_byte_0, m_byte_1, m_byte_2, m_byte_3,
                         m_byte_4, m_byte_5, m_byte_6, m_byte_7};
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected result, msg_id", 32'(m_msg_id), 0);
            end else begin
                want = expected_frames.pop_front();
                if (m_msg_id !== want.id)
                    report_mismatch("msg_id", 32'(m_msg_id), 32'(want.id));
                if (m_msg_len !== want.len)
                    report_mismatch("msg_len", 32'(m_msg_len), 32'(want.len));
                for (int k = 0; k < OUT_BYTES; k++)
                    if (got_byte[k] !== want.data[k])
                        report_mismatch($sformatf("byte_%0d", k), 32'(got_byte[k]),
                                        32'(want.data[k]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned frames;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = 8'h00;
        frames    = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < DIR_COUNT; i++)
            push_rx(DIR_ROWS[i].rx, DIR_ROWS[i].kind, DIR_ROWS[i].res);
        wait_drained();
        while (item_count < ITEMS) begin
            send_random_frame();
            frames++;
            if (frames % 25 == 0) wait_drained();
        end
        wait_drained();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
